FILE: hw/rtl/mbm_pkg.sv
// Shared types, event codes and address decode constants for the multicart
// bank mapper. Used by every module of the mapper; depends on nothing.
package mbm_pkg;

  localparam int A12_FILTER_CYCLES_DEF = 5;
  localparam int A12_FILTER_MAX = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_FETCH = 2'd3
  } mbm_op_t;

  typedef enum logic [3:0] {
    PAGE_PRG  = 4'h8,
    PAGE_MODE = 4'h9,
    PAGE_CHRA = 4'hA,
    PAGE_CHRB = 4'hB,
    PAGE_IRQ  = 4'hC
  } mbm_page_t;

  localparam logic [1:0] MODE_PRG_OUTER = 2'd0;
  localparam logic [1:0] MODE_MASKS     = 2'd1;
  localparam logic [1:0] MODE_MIRROR    = 2'd2;
  localparam logic [1:0] MODE_CHR_OUTER = 2'd3;

  localparam logic [1:0] IRQ_LOW      = 2'd0;
  localparam logic [1:0] IRQ_HIGH     = 2'd1;
  localparam logic [1:0] IRQ_CONTROL  = 2'd2;
  localparam logic [1:0] IRQ_ENABLE   = 2'd3;

  localparam logic [2:0] PRG_SLOT_WRAM = 3'd3;
  localparam logic [2:0] PRG_SLOT_8    = 3'd4;
  localparam logic [2:0] PRG_SLOT_A    = 3'd5;
  localparam logic [2:0] PRG_SLOT_C    = 3'd6;
  localparam logic [2:0] PRG_SLOT_E    = 3'd7;

  localparam logic [5:0] PRG_MASK_RESET = 6'h3F;
  localparam logic [7:0] PRG_FIXED_REG  = 8'hFF;
  localparam logic [7:0] PRG_REG_RESET  = 8'hFC;

  typedef struct packed {
    logic [3:0][7:0] prg_regs;
    logic [7:0][7:0] chr_regs;
    logic [5:0]      prg_mask;
    logic [6:0]      prg_outer;
    logic            chr_mask_full;
    logic [14:0]     chr_outer;
  } mbm_map_t;

  typedef struct packed {
    logic [1:0] mirror_mode;
    logic       irq_line;
  } mbm_status_t;

  function automatic logic [5:0] prg_mask_sel(input logic [1:0] code);
    case (code)
      2'd0:    prg_mask_sel = 6'h3F;
      2'd1:    prg_mask_sel = 6'h1F;
      2'd2:    prg_mask_sel = 6'h2F;
      default: prg_mask_sel = 6'h0F;
    endcase
  endfunction

endpackage

FILE: hw/rtl/mbm_state.sv
// Mapper register file and IRQ counter: applies one event per advance.
// Depends on mbm_pkg.
module mbm_state #(
  parameter int A12_FILTER_CYCLES = mbm_pkg::A12_FILTER_CYCLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  mbm_pkg::mbm_op_t    op,
  input  logic [15:0]         addr,
  input  logic [7:0]          data,
  output mbm_pkg::mbm_map_t   map,
  output mbm_pkg::mbm_status_t status_next
);
  import mbm_pkg::*;

  localparam int A12W = $clog2(A12_FILTER_CYCLES + 1);

  mbm_map_t   map_next;
  logic [1:0] mirroring, mirroring_next;
  logic [15:0] irq_counter, irq_counter_next;
  logic [A12W-1:0] a12_filter, a12_filter_next;
  logic reload_flag, reload_flag_next;
  logic irq_enable, irq_enable_next;
  logic count_a12_mode, count_a12_mode_next;
  logic auto_enable, auto_enable_next;
  logic irq_pending, irq_pending_next;

  always_comb begin
    logic [7:0] lo;
    lo = irq_counter[7:0];
    map_next            = map;
    mirroring_next      = mirroring;
    irq_counter_next    = irq_counter;
    a12_filter_next     = a12_filter;
    reload_flag_next    = reload_flag;
    irq_enable_next     = irq_enable;
    count_a12_mode_next = count_a12_mode;
    auto_enable_next    = auto_enable;
    irq_pending_next    = irq_pending;
    case (op)
      OP_WRITE: begin
        case (addr[15:12])
          PAGE_PRG:  map_next.prg_regs[addr[1:0]] = data;
          PAGE_MODE: begin
            case (addr[1:0])
              MODE_PRG_OUTER: map_next.prg_outer = {data[5:3], 4'b0000};
              MODE_MASKS: begin
                map_next.prg_mask      = prg_mask_sel(data[1:0]);
                map_next.chr_mask_full = data[6];
              end
              MODE_MIRROR: mirroring_next = data[1:0];
              default:     map_next.chr_outer = {data, 7'b0000000};
            endcase
          end
          PAGE_CHRA: map_next.chr_regs[{1'b0, addr[1:0]}] = data;
          PAGE_CHRB: map_next.chr_regs[{1'b1, addr[1:0]}] = data;
          PAGE_IRQ: begin
            case (addr[1:0])
              IRQ_LOW: begin
                if (auto_enable) irq_enable_next = 1'b0;
                irq_counter_next[7:0] = data;
              end
              IRQ_HIGH: begin
                if (auto_enable) irq_enable_next = 1'b1;
                irq_counter_next[15:8] = data;
                reload_flag_next = 1'b1;
              end
              IRQ_CONTROL: begin
                irq_enable_next     = data[0];
                count_a12_mode_next = data[1];
                auto_enable_next    = data[2];
              end
              default: irq_enable_next = data[0];
            endcase
            irq_pending_next = 1'b0;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (a12_filter != '0) a12_filter_next = a12_filter - 1'b1;
        if (irq_enable && !count_a12_mode && irq_counter != 16'h0000) begin
          irq_counter_next = irq_counter - 16'h0001;
          if (irq_counter == 16'h0001) irq_pending_next = 1'b1;
        end
      end
      OP_FETCH: begin
        if (addr[12]) begin
          if (a12_filter == '0 && count_a12_mode) begin
            if (lo == 8'h00 || reload_flag) lo = irq_counter[15:8];
            else lo = lo - 8'h01;
            irq_counter_next[7:0] = lo;
            if (lo == 8'h00 && irq_enable) irq_pending_next = 1'b1;
            reload_flag_next = 1'b0;
          end
          a12_filter_next = A12W'(A12_FILTER_CYCLES);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) map.prg_regs[i] <= PRG_REG_RESET | 8'(i);
      for (int i = 0; i < 8; i++) map.chr_regs[i] <= 8'(i);
      map.prg_mask      <= PRG_MASK_RESET;
      map.prg_outer     <= '0;
      map.chr_mask_full <= 1'b1;
      map.chr_outer     <= '0;
      mirroring         <= '0;
      irq_counter       <= '0;
      a12_filter        <= '0;
      reload_flag       <= 1'b0;
      irq_enable        <= 1'b0;
      count_a12_mode    <= 1'b0;
      auto_enable       <= 1'b0;
      irq_pending       <= 1'b0;
    end else if (advance) begin
      map            <= map_next;
      mirroring      <= mirroring_next;
      irq_counter    <= irq_counter_next;
      a12_filter     <= a12_filter_next;
      reload_flag    <= reload_flag_next;
      irq_enable     <= irq_enable_next;
      count_a12_mode <= count_a12_mode_next;
      auto_enable    <= auto_enable_next;
      irq_pending    <= irq_pending_next;
    end
  end

  assign status_next.mirror_mode = mirroring_next;
  assign status_next.irq_line    = irq_pending_next;

endmodule

FILE: hw/rtl/mbm_lookup.sv
// PRG and CHR bank translation from the current bank registers.
// Depends on mbm_pkg.
module mbm_lookup (
  input  mbm_pkg::mbm_op_t  op,
  input  logic [15:0]       addr,
  input  mbm_pkg::mbm_map_t map,
  input  logic              chr_rom_present,
  input  logic              variant_2k_chr,
  output logic [6:0]        prg_bank,
  output logic [14:0]       chr_bank,
  output logic              chr_is_ram
);
  import mbm_pkg::*;

  logic [6:0]  prg_map;
  logic [7:0]  prg_reg;
  logic [2:0]  page;
  logic [7:0]  chr_reg;
  logic [2:0]  pair_idx;
  logic [14:0] chr_map;

  always_comb begin
    prg_reg = PRG_FIXED_REG;
    case (addr[15:13])
      PRG_SLOT_WRAM: prg_reg = map.prg_regs[3];
      PRG_SLOT_8:    prg_reg = map.prg_regs[0];
      PRG_SLOT_A:    prg_reg = map.prg_regs[1];
      PRG_SLOT_C:    prg_reg = map.prg_regs[2];
      default:       prg_reg = PRG_FIXED_REG;
    endcase
    prg_map = {1'b0, prg_reg[5:0] & map.prg_mask} | map.prg_outer;
    if (addr[15:13] < PRG_SLOT_WRAM) prg_map = '0;
  end

  assign page = addr[12:10];

  always_comb begin
    case (page[2:1])
      2'd0:    pair_idx = 3'd0;
      2'd1:    pair_idx = 3'd1;
      2'd2:    pair_idx = 3'd6;
      default: pair_idx = 3'd7;
    endcase
    chr_reg = map.chr_regs[page];
    if (!chr_rom_present) begin
      chr_map = {12'b0, page};
    end else if (variant_2k_chr) begin
      chr_map = {6'b0, map.chr_regs[pair_idx], page[0]};
    end else begin
      chr_map = {7'b0, chr_reg[7] & map.chr_mask_full, chr_reg[6:0]} | map.chr_outer;
    end
  end

  assign prg_bank   = (op == OP_READ) ? prg_map : '0;
  assign chr_bank   = (op == OP_FETCH) ? chr_map : '0;
  assign chr_is_ram = (op == OP_FETCH) && !chr_rom_present;

endmodule

FILE: hw/rtl/multicart_bank_mapper_irq.sv
// Top level of the multicart bank mapper: input stage, register file,
// bank lookup and result register. Depends on mbm_pkg, mbm_state, mbm_lookup.
//
//  channel | signals                              | item
//  --------+--------------------------------------+---------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser    | bus event (kind, address, data)
//  m_      | m_tvalid m_tready m_tdata m_tuser    | bank lookup and status
//  cfg_    | cfg_we cfg_index cfg_wdata           | cartridge setup registers
//
// An item accepted at the input is held in the input register; the register
// file update and bank lookup then load the result register once it can take
// the item. One item per clock is sustained while m_tready stays high.
// A stalled result holds the input register; the input side keeps taking
// items as long as the input register can move on. Reset is synchronous.
module multicart_bank_mapper_irq #(
  parameter int A12_FILTER_CYCLES = mbm_pkg::A12_FILTER_CYCLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // prg_bank[6:0], chr_bank[21:7], mirror_mode[23:22],
                                 // irq_line[24], zero[31:25]
  output logic        m_tuser,   // chr_is_ram[0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);
  import mbm_pkg::*;

  localparam logic CFG_CHR_ROM = 1'b0;

  logic        chr_rom_present;
  logic        variant_2k_chr;
  logic        s1_valid;
  mbm_op_t     s1_op;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;
  logic        advance;
  mbm_map_t    map;
  mbm_status_t status_next;
  logic [6:0]  prg_bank;
  logic [14:0] chr_bank;
  logic        chr_is_ram;

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_rom_present <= 1'b1;
      variant_2k_chr  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHR_ROM) chr_rom_present <= cfg_wdata;
      else variant_2k_chr <= cfg_wdata;
    end
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_op   <= mbm_op_t'(s_tuser);
      s1_addr <= s_tdata[15:0];
      s1_data <= s_tdata[23:16];
    end
  end

  mbm_state #(
    .A12_FILTER_CYCLES(A12_FILTER_CYCLES)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .op         (s1_op),
    .addr       (s1_addr),
    .data       (s1_data),
    .map        (map),
    .status_next(status_next)
  );

  mbm_lookup u_lookup (
    .op             (s1_op),
    .addr           (s1_addr),
    .map            (map),
    .chr_rom_present(chr_rom_present),
    .variant_2k_chr (variant_2k_chr),
    .prg_bank       (prg_bank),
    .chr_bank       (chr_bank),
    .chr_is_ram     (chr_is_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'b0, status_next.irq_line, status_next.mirror_mode, chr_bank, prg_bank};
      m_tuser <= chr_is_ram;
    end
  end

endmodule

FILE: dv/multicart_bank_mapper_irq_tb.sv
// Self-checking bench for the multicart bank mapper: directed and random bus events,
// a built-in mapper predictor and a field-by-field compare of every result item.
// Depends on mbm_pkg and multicart_bank_mapper_irq.
`timescale 1ns / 1ps

module multicart_bank_mapper_irq_tb;
  import mbm_pkg::*;

  localparam logic CFG_CHR_ROM    = 1'b0;
  localparam logic CFG_VARIANT_2K = 1'b1;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   HOLD_OFF_CYCLES = 250;
  localparam int   HOLD_OFF_AFTER = 500;
  localparam logic [2:0] A12_HOLDOFF_LOAD = 3'(A12_FILTER_CYCLES_DEF);

  typedef struct packed {
    mbm_op_t     op;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_event_t;

  typedef struct packed {
    logic [6:0]  prg_bank;
    logic [14:0] chr_bank;
    logic        chr_is_ram;
    logic [1:0]  mirror_mode;
    logic        irq_line;
  } bank_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;

  multicart_bank_mapper_irq dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_event_t   pending_ev[$];
  bank_result_t bank_expect[$];
  bus_event_t   cur_ev;
  logic         calm = 1'b0;
  int           sent_cnt = 0;
  int           result_cnt = 0;
  int           mismatches = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  int           quiet_cyc = 0;

  // mapper state as the bank lookups see it
  logic        cart_chr_rom;
  logic        cart_2k_chr;
  logic [7:0]  prg_bank_reg [4];
  logic [7:0]  chr_bank_reg [8];
  logic [5:0]  prg_and;
  logic [6:0]  prg_or;
  logic        chr_and_full;
  logic [14:0] chr_or;
  logic [1:0]  mirror_sel;
  logic [15:0] irq_count;
  logic [2:0]  a12_holdoff;
  logic        irq_reload;
  logic        irq_armed;
  logic        irq_a12_mode;
  logic        irq_auto;
  logic        irq_flag;

  function automatic void reset_mapper();
    cart_chr_rom = 1'b1;
    cart_2k_chr  = 1'b0;
    for (int i = 0; i < 4; i++) prg_bank_reg[i] = PRG_REG_RESET | 8'(i);
    for (int i = 0; i < 8; i++) chr_bank_reg[i] = 8'(i);
    prg_and      = PRG_MASK_RESET;
    prg_or       = '0;
    chr_and_full = 1'b1;
    chr_or       = '0;
    mirror_sel   = '0;
    irq_count    = '0;
    a12_holdoff  = '0;
    irq_reload   = 1'b0;
    irq_armed    = 1'b0;
    irq_a12_mode = 1'b0;
    irq_auto     = 1'b0;
    irq_flag     = 1'b0;
  endfunction

  function automatic bank_result_t map_event(bus_event_t ev);
    bank_result_t r;
    logic [1:0]   sub;
    logic [2:0]   page;
    logic [2:0]   idx;
    logic [7:0]   sel;
    logic [7:0]   lo;
    logic         hit;
    r    = '0;
    sub  = ev.addr[1:0];
    page = ev.addr[12:10];
    hit  = 1'b1;
    sel  = '0;
    case (ev.op)
      OP_WRITE: begin
        case (ev.addr[15:12])
          PAGE_PRG: prg_bank_reg[sub] = ev.data;
          PAGE_MODE: begin
            case (sub)
              MODE_PRG_OUTER: prg_or = {ev.data[5:3], 4'b0000};
              MODE_MASKS: begin
                case (ev.data[1:0])
                  2'd0:    prg_and = 6'h3F;
                  2'd1:    prg_and = 6'h1F;
                  2'd2:    prg_and = 6'h2F;
                  default: prg_and = 6'h0F;
                endcase
                chr_and_full = ev.data[6];
              end
              MODE_MIRROR: mirror_sel = ev.data[1:0];
              default: chr_or = {ev.data, 7'b0000000};
            endcase
          end
          PAGE_CHRA: chr_bank_reg[{1'b0, sub}] = ev.data;
          PAGE_CHRB: chr_bank_reg[{1'b1, sub}] = ev.data;
          PAGE_IRQ: begin
            case (sub)
              IRQ_LOW: begin
                if (irq_auto) irq_armed = 1'b0;
                irq_count[7:0] = ev.data;
              end
              IRQ_HIGH: begin
                if (irq_auto) irq_armed = 1'b1;
                irq_count[15:8] = ev.data;
                irq_reload = 1'b1;
              end
              IRQ_CONTROL: begin
                irq_armed    = ev.data[0];
                irq_a12_mode = ev.data[1];
                irq_auto     = ev.data[2];
              end
              default: irq_armed = ev.data[0];
            endcase
            irq_flag = 1'b0;
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (ev.addr[15:13])
          PRG_SLOT_WRAM: sel = prg_bank_reg[3];
          PRG_SLOT_8:    sel = prg_bank_reg[0];
          PRG_SLOT_A:    sel = prg_bank_reg[1];
          PRG_SLOT_C:    sel = prg_bank_reg[2];
          PRG_SLOT_E:    sel = PRG_FIXED_REG;
          default:       hit = 1'b0;
        endcase
        if (hit) r.prg_bank = {1'b0, sel[5:0] & prg_and} | prg_or;
      end
      OP_TICK: begin
        if (a12_holdoff != 0) a12_holdoff = a12_holdoff - 3'd1;
        if (irq_armed && !irq_a12_mode && irq_count != 0) begin
          irq_count = irq_count - 16'd1;
          if (irq_count == 0) irq_flag = 1'b1;
        end
      end
      default: begin
        if (ev.addr[12]) begin
          if (a12_holdoff == 0 && irq_a12_mode) begin
            lo = irq_count[7:0];
            if (lo == 0 || irq_reload) lo = irq_count[15:8];
            else lo = lo - 8'd1;
            irq_count[7:0] = lo;
            if (lo == 0 && irq_armed) irq_flag = 1'b1;
            irq_reload = 1'b0;
          end
          a12_holdoff = A12_HOLDOFF_LOAD;
        end
        if (!cart_chr_rom) begin
          r.chr_bank = {12'd0, page};
        end else if (cart_2k_chr) begin
          idx = {page[2], page[2], page[1]};
          r.chr_bank = {6'd0, chr_bank_reg[idx], page[0]};
        end else begin
          sel = chr_bank_reg[page];
          r.chr_bank = {7'd0, chr_and_full & sel[7], sel[6:0]} | chr_or;
        end
        r.chr_is_ram = !cart_chr_rom;
      end
    endcase
    r.mirror_mode = mirror_sel;
    r.irq_line    = irq_flag;
    return r;
  endfunction

  always @(posedge clk) begin : drive_proc
    bus_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        bank_expect.push_back(map_event(cur_ev));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ev.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          ev = pending_ev.pop_front();
          cur_ev = ev;
          s_tdata  <= {ev.data, ev.addr};
          s_tuser  <= ev.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_OFF_AFTER) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("result %0d %s: expected 0x%0h, got 0x%0h", result_cnt, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_proc
    bank_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bank_expect.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d: unexpected item, data 0x%0h", result_cnt, m_tdata);
          mismatches++;
        end else begin
          want = bank_expect.pop_front();
          check_field("prg_bank", want.prg_bank, m_tdata[6:0]);
          check_field("chr_bank", want.chr_bank, m_tdata[21:7]);
          check_field("mirror_mode", want.mirror_mode, m_tdata[23:22]);
          check_field("irq_line", want.irq_line, m_tdata[24]);
          check_field("pad", 0, m_tdata[31:25]);
          check_field("chr_is_ram", want.chr_is_ram, m_tuser);
        end
        result_cnt++;
      end
      m_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WATCHDOG_LIMIT) begin
      $display("FAIL multicart_bank_mapper_irq");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  task automatic queue_event(mbm_op_t op, logic [15:0] addr, logic [7:0] data);
    bus_event_t ev;
    ev.op   = op;
    ev.addr = addr;
    ev.data = data;
    pending_ev.push_back(ev);
  endtask

  task automatic queue_random();
    int unsigned pick;
    int unsigned n_ticks;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    if (pick < 10) begin
      // scanline: A12 low, A12 rise, then CPU ticks, not always enough to clear the filter
      n_ticks = $urandom_range(3, 8);
      queue_event(OP_FETCH, a & 16'hEFFF, d);
      queue_event(OP_FETCH, a | 16'h1000, d);
      for (int k = 0; k < n_ticks; k++) queue_event(OP_TICK, 16'($urandom), 8'($urandom));
    end else if (pick < 32) begin
      if ($urandom_range(0, 3) != 0) a[15:13] = 3'($urandom_range(3, 7));
      queue_event(OP_READ, a, d);
    end else if (pick < 52) begin
      queue_event(OP_FETCH, a, d);
    end else if (pick < 70) begin
      queue_event(OP_TICK, a, d);
    end else begin
      if ($urandom_range(0, 9) != 0) a[15:12] = 4'($urandom_range(8, 12));
      if (a[15:12] == PAGE_IRQ && (a[1:0] == IRQ_LOW || a[1:0] == IRQ_HIGH) &&
          $urandom_range(0, 3) != 0)
        d = 8'($urandom_range(0, 6));
      queue_event(OP_WRITE, a, d);
    end
  endtask

  task automatic write_cfg(logic idx, logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHR_ROM) cart_chr_rom = val;
    else cart_2k_chr = val;
  endtask

  task automatic drain();
    while (pending_ev.size() != 0 || s_tvalid || bank_expect.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stim_proc
    int phase_len [4];
    phase_len[0] = 350;
    phase_len[1] = 300;
    phase_len[2] = 250;
    phase_len[3] = 250;
    reset_mapper();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_event(OP_READ,  16'h0000, 8'h00);
    queue_event(OP_READ,  16'h6000, 8'h00);
    queue_event(OP_READ,  16'h9FFF, 8'h00);
    queue_event(OP_READ,  16'hFFFF, 8'hFF);
    queue_event(OP_FETCH, 16'h0000, 8'h00);
    queue_event(OP_FETCH, 16'hFFFF, 8'hFF);
    queue_event(OP_WRITE, 16'h8000, 8'hFF);
    queue_event(OP_WRITE, 16'h9001, 8'hFF);
    queue_event(OP_WRITE, 16'h9000, 8'hFF);
    queue_event(OP_WRITE, 16'h9003, 8'hFF);
    queue_event(OP_WRITE, 16'h9002, 8'h03);
    queue_event(OP_WRITE, 16'hA000, 8'hFF);
    queue_event(OP_WRITE, 16'hB003, 8'h00);
    queue_event(OP_WRITE, 16'hD001, 8'h55);
    queue_event(OP_WRITE, 16'h7FFF, 8'hAA);
    queue_event(OP_READ,  16'h8000, 8'h00);
    queue_event(OP_FETCH, 16'h0000, 8'h00);
    queue_event(OP_FETCH, 16'h1C00, 8'h00);
    queue_event(OP_WRITE, 16'hC002, 8'h01);
    queue_event(OP_WRITE, 16'hC000, 8'h02);
    queue_event(OP_WRITE, 16'hC001, 8'h00);
    queue_event(OP_TICK,  16'h0000, 8'h00);
    queue_event(OP_TICK,  16'h0000, 8'h00);
    queue_event(OP_TICK,  16'h0000, 8'h00);
    queue_event(OP_WRITE, 16'hC003, 8'h00);
    queue_event(OP_WRITE, 16'h9001, 8'h00);
    queue_event(OP_FETCH, 16'h0400, 8'h00);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_CHR_ROM, (ph < 2) ? 1'b1 : 1'b0);
      write_cfg(CFG_VARIANT_2K, ph[0]);
      calm = (ph == 0);
      while (pending_ev.size() < phase_len[ph]) queue_random();
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && bank_expect.size() == 0) begin
      $display("PASS multicart_bank_mapper_irq");
    end else begin
      $display("FAIL multicart_bank_mapper_irq");
    end
    $finish;
  end

endmodule
